@@ hw/rtl/vtt_pkg.sv @@
// Package of shared types and codes for the virtual timer table.
`timescale 1ns / 1ps
package vtt_pkg;

	// operation codes carried in s_tuser
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_RESET = 2'd1,
		OP_STOP  = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	// reply kinds carried in m_tuser
	typedef enum logic [1:0] {
		KIND_START  = 2'd0,
		KIND_RESET  = 2'd1,
		KIND_STOP   = 2'd2,
		KIND_EXPIRY = 2'd3
	} kind_t;

	// reply status codes
	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_INVALID = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START_LINK,
		ST_RD,
		ST_EX,
		ST_OUT
	} state_t;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 24;

endpackage

@@ hw/rtl/virtual_timer_table.sv @@
// Virtual timer table: slot allocation, linked timer list and tick walk.
`timescale 1ns / 1ps
// Keeps up to SLOTS software timers in a doubly linked list held in three
// single-port-style memories (timer data, older links, newer links), each
// read through a register. One item is handled at a time: a start writes the
// entry, then links the old newest one to it; a reset rewrites a live entry;
// a stop reads the entry, then unlinks it (a dead slot or a full table goes
// straight to the reply), then each reply is offered on the master side. A
// tick walks the live timers from newest to oldest, each by a memory read,
// then update and write back; its expiry items (one per expired timer, none
// if nothing expired) then leave at one per cycle while the receiver is
// ready. Every reply carries the live count after the whole item, so tick
// replies are buffered until the walk ends. No clearing pass follows reset.
module virtual_timer_table #(
	parameter int SLOTS      = 16,
	parameter int COUNT_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// slot[3:0], timer_mode[4], delay_ticks[36:5], event_tag[44:37], zeros above
	input  logic [vtt_pkg::IN_DATA_W-1:0]     s_tdata,
	// operation[1:0]
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// status[1:0], result_slot[5:2], result_tag[13:6], active_count[18:14], zeros above
	output logic [vtt_pkg::OUT_DATA_W-1:0]    m_tdata,
	// reply_kind[1:0]
	output logic [1:0]                        m_tuser,
	output logic                              m_tlast
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW = $clog2(SLOTS + 1);
	localparam int DW = 2 * COUNT_BITS + 9;
	localparam logic [LW-1:0] NIL = LW'(SLOTS);

	// input fields
	logic [3:0]            in_slot;
	logic                  in_mode;
	logic [31:0]           in_delay;
	logic [7:0]            in_tag;
	vtt_pkg::op_t          in_op;
	logic [COUNT_BITS-1:0] in_delay_w;

	assign in_slot    = s_tdata[3:0];
	assign in_mode    = s_tdata[4];
	assign in_delay   = s_tdata[36:5];
	assign in_tag     = s_tdata[44:37];
	assign in_op      = vtt_pkg::op_t'(s_tuser);
	assign in_delay_w = COUNT_BITS'(in_delay);

	// control state
	vtt_pkg::state_t    state_q, state_d;
	vtt_pkg::op_t       op_q;
	vtt_pkg::kind_t     kind_q;
	vtt_pkg::status_t   status_q;
	logic [SLOTS-1:0]   valid_q;
	logic [LW-1:0]      newest_q;
	logic [LW-1:0]      live_q;
	logic [LW-1:0]      cur_q;
	logic [LW-1:0]      guard_q;
	logic [LW-1:0]      prev_q;
	logic [LW-1:0]      found_q;
	logic [LW-1:0]      res_n_q;
	logic [LW-1:0]      rd_idx_q;

	// memories and their read registers
	logic [DW-1:0]      data_mem  [SLOTS];
	logic [LW-1:0]      older_mem [SLOTS];
	logic [LW-1:0]      newer_mem [SLOTS];
	logic [DW-1:0]      data_rd_q;
	logic [LW-1:0]      older_rd_q;
	logic [LW-1:0]      newer_rd_q;

	// buffered replies of one item
	logic [3:0]         res_slot_q [SLOTS];
	logic [7:0]         res_tag_q  [SLOTS];

	// write ports
	logic               dwe, owe, nwe;
	logic [IW-1:0]      dwaddr, owaddr, nwaddr;
	logic [DW-1:0]      dwdata;
	logic [LW-1:0]      owdata, nwdata;

	logic               s_fire, m_fire;
	logic               in_rng, in_live;
	logic [LW-1:0]      free_slot;
	logic               free_ok;

	assign s_fire = s_tvalid && s_tready;
	assign m_fire = m_tvalid && m_tready;

	// handle checks
	assign in_rng  = (32'(in_slot) < SLOTS);
	assign in_live = in_rng && valid_q[IW'(in_slot)];

	// lowest free slot
	always_comb begin
		free_slot = NIL;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_slot = LW'(i);
			end
		end
	end
	assign free_ok = (free_slot != NIL);

	// fields of the entry read back for the walk
	logic [COUNT_BITS-1:0] rd_count, rd_delay, cnt1;
	logic [7:0]            rd_tag;
	logic                  rd_mode;
	logic                  hit, do_unlink, walk_end, last_res;

	assign rd_count  = data_rd_q[COUNT_BITS-1:0];
	assign rd_delay  = data_rd_q[2*COUNT_BITS-1:COUNT_BITS];
	assign rd_tag    = data_rd_q[2*COUNT_BITS+7:2*COUNT_BITS];
	assign rd_mode   = data_rd_q[2*COUNT_BITS+8];
	assign cnt1      = rd_count + 1'b1;
	assign hit       = (cnt1 == rd_delay);
	assign do_unlink = (op_q == vtt_pkg::OP_STOP) || (hit && !rd_mode);
	assign walk_end  = (guard_q == LW'(SLOTS)) || (cur_q == NIL);
	assign last_res  = (LW'(rd_idx_q + 1'b1) == res_n_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			vtt_pkg::ST_IDLE: begin
				if (s_fire) begin
					case (in_op)
						vtt_pkg::OP_START: state_d = free_ok ? vtt_pkg::ST_START_LINK
						                                     : vtt_pkg::ST_OUT;
						vtt_pkg::OP_RESET: state_d = vtt_pkg::ST_OUT;
						vtt_pkg::OP_STOP:  state_d = in_live ? vtt_pkg::ST_RD
						                                     : vtt_pkg::ST_OUT;
						default:           state_d = vtt_pkg::ST_RD;
					endcase
				end
			end
			vtt_pkg::ST_START_LINK: state_d = vtt_pkg::ST_OUT;
			vtt_pkg::ST_RD: begin
				if (op_q == vtt_pkg::OP_TICK && walk_end) begin
					state_d = (res_n_q == '0) ? vtt_pkg::ST_IDLE : vtt_pkg::ST_OUT;
				end else begin
					state_d = vtt_pkg::ST_EX;
				end
			end
			vtt_pkg::ST_EX: state_d = (op_q == vtt_pkg::OP_STOP) ? vtt_pkg::ST_OUT
			                                                      : vtt_pkg::ST_RD;
			vtt_pkg::ST_OUT: begin
				if (m_fire && last_res) begin
					state_d = vtt_pkg::ST_IDLE;
				end
			end
			default: state_d = vtt_pkg::ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		s_tready = (state_q == vtt_pkg::ST_IDLE);
		m_tvalid = (state_q == vtt_pkg::ST_OUT);
	end

	// reply payload from the buffer
	assign m_tuser = kind_q;
	assign m_tlast = last_res;
	assign m_tdata = {5'd0, 5'(live_q), res_tag_q[rd_idx_q[IW-1:0]],
	                  res_slot_q[rd_idx_q[IW-1:0]], status_q};

	// memory write controls
	always_comb begin
		dwe    = 1'b0;
		owe    = 1'b0;
		nwe    = 1'b0;
		dwaddr = '0;
		owaddr = '0;
		nwaddr = '0;
		dwdata = '0;
		owdata = '0;
		nwdata = '0;
		case (state_q)
			vtt_pkg::ST_IDLE: begin
				if (s_fire && in_op == vtt_pkg::OP_START && free_ok) begin
					dwe    = 1'b1;
					dwaddr = free_slot[IW-1:0];
					dwdata = {in_mode, in_tag, in_delay_w, {COUNT_BITS{1'b0}}};
					owe    = 1'b1;
					owaddr = free_slot[IW-1:0];
					owdata = newest_q;
					nwe    = 1'b1;
					nwaddr = free_slot[IW-1:0];
					nwdata = NIL;
				end else if (s_fire && in_op == vtt_pkg::OP_RESET && in_live) begin
					dwe    = 1'b1;
					dwaddr = IW'(in_slot);
					dwdata = {in_mode, in_tag, in_delay_w, {COUNT_BITS{1'b0}}};
				end
			end
			vtt_pkg::ST_START_LINK: begin
				// old newest entry points to the new one
				nwe    = (prev_q != NIL);
				nwaddr = prev_q[IW-1:0];
				nwdata = found_q;
			end
			vtt_pkg::ST_EX: begin
				if (do_unlink) begin
					owe    = (newer_rd_q != NIL);
					owaddr = newer_rd_q[IW-1:0];
					owdata = older_rd_q;
					nwe    = (older_rd_q != NIL);
					nwaddr = older_rd_q[IW-1:0];
					nwdata = newer_rd_q;
				end else begin
					dwe    = 1'b1;
					dwaddr = cur_q[IW-1:0];
					dwdata = {rd_mode, rd_tag, rd_delay,
					          hit ? {COUNT_BITS{1'b0}} : cnt1};
				end
			end
			default: ;
		endcase
	end

	// memories, read registers and reply buffer
	always_ff @(posedge clk) begin
		if (dwe) data_mem[dwaddr] <= dwdata;
		if (owe) older_mem[owaddr] <= owdata;
		if (nwe) newer_mem[nwaddr] <= nwdata;
		data_rd_q  <= data_mem[cur_q[IW-1:0]];
		older_rd_q <= older_mem[cur_q[IW-1:0]];
		newer_rd_q <= newer_mem[cur_q[IW-1:0]];
		if (state_q == vtt_pkg::ST_IDLE && s_fire) begin
			// a full table answers with slot 0
			res_slot_q[0] <= (in_op != vtt_pkg::OP_START) ? in_slot
			                 : (free_ok ? 4'(free_slot) : 4'd0);
			res_tag_q[0]  <= 8'd0;
		end else if (state_q == vtt_pkg::ST_EX && op_q == vtt_pkg::OP_TICK && hit) begin
			res_slot_q[res_n_q[IW-1:0]] <= 4'(cur_q);
			res_tag_q[res_n_q[IW-1:0]]  <= rd_tag;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= vtt_pkg::ST_IDLE;
			op_q     <= vtt_pkg::OP_START;
			kind_q   <= vtt_pkg::KIND_START;
			status_q <= vtt_pkg::STAT_OK;
			valid_q  <= '0;
			newest_q <= NIL;
			live_q   <= '0;
			cur_q    <= NIL;
			guard_q  <= '0;
			prev_q   <= NIL;
			found_q  <= NIL;
			res_n_q  <= '0;
			rd_idx_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				vtt_pkg::ST_IDLE: begin
					if (s_fire) begin
						op_q     <= in_op;
						kind_q   <= vtt_pkg::kind_t'(in_op);
						status_q <= (in_op == vtt_pkg::OP_START && !free_ok)
						            ? vtt_pkg::STAT_FULL
						            : ((in_op == vtt_pkg::OP_RESET && !in_live)
						               ? vtt_pkg::STAT_INVALID : vtt_pkg::STAT_OK);
						rd_idx_q <= '0;
						res_n_q  <= (in_op == vtt_pkg::OP_TICK) ? '0 : LW'(1);
						guard_q  <= '0;
						case (in_op)
							vtt_pkg::OP_START: begin
								if (free_ok) begin
									valid_q[free_slot[IW-1:0]] <= 1'b1;
									live_q   <= live_q + 1'b1;
									prev_q   <= newest_q;
									found_q  <= free_slot;
									newest_q <= free_slot;
								end
							end
							vtt_pkg::OP_RESET: ;
							vtt_pkg::OP_STOP: begin
								cur_q <= LW'(in_slot);
							end
							default: begin
								cur_q <= newest_q;
							end
						endcase
					end
				end
				vtt_pkg::ST_EX: begin
					if (do_unlink) begin
						valid_q[cur_q[IW-1:0]] <= 1'b0;
						if (live_q != '0) live_q <= live_q - 1'b1;
						if (newer_rd_q == NIL) newest_q <= older_rd_q;
					end
					if (op_q == vtt_pkg::OP_TICK) begin
						if (hit) res_n_q <= res_n_q + 1'b1;
						cur_q   <= older_rd_q;
						guard_q <= guard_q + 1'b1;
					end
				end
				vtt_pkg::ST_OUT: begin
					if (m_fire && !last_res) rd_idx_q <= rd_idx_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

@@ hw/rtl/vtt_check.sv @@
// Port-level checks for the virtual timer table, bound to the top level.
`timescale 1ns / 1ps
module vtt_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// one item at a time: never taking input while replies are offered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while replies pending");

	// an accepted item closes the input side in the cycle after it
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready not dropped after accepted item");

	// more replies follow a non-final one at once
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("reply run broken before last");

	// table full only answers a start
	a_full_is_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == 2'd1 |-> m_tuser == 2'd0 && m_tlast)
		else $error("table full on a non-start reply");

	// a stalled reply holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled reply changed");

endmodule

bind virtual_timer_table vtt_check u_vtt_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

@@ sim/tb_virtual_timer_table.sv @@
// Self-checking testbench for the virtual timer table: directed and random items.
`timescale 1ns / 1ps
module tb_virtual_timer_table;

	localparam int SLOTS = 16;
	localparam logic [4:0] NO_SLOT = 5'd16;
	localparam int TAIL_CYCLES = 80;
	localparam int HOLD_CYCLES = 400;

	// one reply as seen on the master side
	typedef struct packed {
		vtt_pkg::kind_t   kind;
		vtt_pkg::status_t status;
		logic [3:0]       slot;
		logic [7:0]       tag;
		logic [4:0]       count;
		logic             last;
	} reply_t;

	// timer list shadow and queue of replies still to come
	class timer_scoreboard;
		bit          live[SLOTS];
		bit          periodic[SLOTS];
		logic [31:0] ticks[SLOTS];
		logic [31:0] period[SLOTS];
		logic [7:0]  tag_of[SLOTS];
		logic [4:0]  older[SLOTS];
		logic [4:0]  newer[SLOTS];
		logic [4:0]  newest;
		int          nlive;
		reply_t      replies_due[$];
		int          errors;
		int          checked;
		int          expiries;

		function void clear();
			foreach (live[i]) live[i] = 0;
			newest = NO_SLOT;
			nlive = 0;
			replies_due.delete();
			errors = 0;
			checked = 0;
			expiries = 0;
		endfunction

		function void unlink(int s);
			logic [4:0] o;
			logic [4:0] n;
			o = older[s];
			n = newer[s];
			if (n != NO_SLOT) older[n] = o;
			else newest = o;
			if (o != NO_SLOT) newer[o] = n;
			live[s] = 0;
			if (nlive > 0) nlive--;
		endfunction

		// work out the replies of one accepted item
		function void note_item(vtt_pkg::op_t op, logic [3:0] slot, bit mode,
				logic [31:0] delay, logic [7:0] tag);
			reply_t r[$];
			reply_t one;
			int found;
			int cur;
			int nxt;
			found = -1;
			one = '0;
			case (op)
				vtt_pkg::OP_START: begin
					for (int s = 0; s < SLOTS; s++)
						if (!live[s] && found < 0) found = s;
					one.kind = vtt_pkg::KIND_START;
					if (found < 0) begin
						one.status = vtt_pkg::STAT_FULL;
					end else begin
						live[found] = 1;
						periodic[found] = mode;
						period[found] = delay;
						tag_of[found] = tag;
						ticks[found] = 0;
						newer[found] = NO_SLOT;
						older[found] = newest;
						if (newest != NO_SLOT) newer[newest] = 5'(found);
						newest = 5'(found);
						nlive++;
						one.status = vtt_pkg::STAT_OK;
						one.slot = 4'(found);
					end
					r.push_back(one);
				end
				vtt_pkg::OP_RESET: begin
					one.kind = vtt_pkg::KIND_RESET;
					one.slot = slot;
					if (live[slot]) begin
						ticks[slot] = 0;
						periodic[slot] = mode;
						period[slot] = delay;
						tag_of[slot] = tag;
						one.status = vtt_pkg::STAT_OK;
					end else begin
						one.status = vtt_pkg::STAT_INVALID;
					end
					r.push_back(one);
				end
				vtt_pkg::OP_STOP: begin
					// a stop of a dead slot still answers ok
					if (live[slot]) unlink(slot);
					one.kind = vtt_pkg::KIND_STOP;
					one.status = vtt_pkg::STAT_OK;
					one.slot = slot;
					r.push_back(one);
				end
				default: begin
					// walk newest to oldest; older link read before any free
					cur = newest;
					for (int g = 0; g < SLOTS && cur != NO_SLOT; g++) begin
						nxt = older[cur];
						ticks[cur] = ticks[cur] + 1;
						if (ticks[cur] == period[cur]) begin
							one = '0;
							one.kind = vtt_pkg::KIND_EXPIRY;
							one.status = vtt_pkg::STAT_OK;
							one.slot = 4'(cur);
							one.tag = tag_of[cur];
							if (!periodic[cur]) unlink(cur);
							else ticks[cur] = 0;
							r.push_back(one);
							expiries++;
						end
						cur = nxt;
					end
				end
			endcase
			foreach (r[k]) begin
				r[k].count = nlive[4:0];
				r[k].last = (k == r.size() - 1);
				replies_due.push_back(r[k]);
			end
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			checked++;
			if (replies_due.size() == 0) begin
				$display("%0t: unexpected reply %p", $time, got);
				errors++;
				return;
			end
			want = replies_due.pop_front();
			if (got.kind !== want.kind) begin
				$display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
				errors++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.slot !== want.slot) begin
				$display("%0t: slot exp %0d got %0d", $time, want.slot, got.slot);
				errors++;
			end
			if (got.tag !== want.tag) begin
				$display("%0t: tag exp %0h got %0h", $time, want.tag, got.tag);
				errors++;
			end
			if (got.count !== want.count) begin
				$display("%0t: count exp %0d got %0d", $time, want.count, got.count);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last exp %0b got %0b", $time, want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [vtt_pkg::IN_DATA_W-1:0]   s_tdata;
	logic [1:0]                      s_tuser;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [vtt_pkg::OUT_DATA_W-1:0]  m_tdata;
	logic [1:0]                      m_tuser;
	logic                            m_tlast;

	timer_scoreboard sb;
	int idle_pct;
	int stall_pct;
	bit long_hold;
	bit hold_done;
	int hold_left;
	int items_sent;

	virtual_timer_table #(.SLOTS(SLOTS), .COUNT_BITS(32)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (long_hold && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// reply monitor
	always @(posedge clk) begin
		reply_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = vtt_pkg::kind_t'(m_tuser);
			got.status = vtt_pkg::status_t'(m_tdata[1:0]);
			got.slot = m_tdata[5:2];
			got.tag = m_tdata[13:6];
			got.count = m_tdata[18:14];
			got.last = m_tlast;
			sb.check_reply(got);
		end
	end

	task automatic send_item(vtt_pkg::op_t op, logic [3:0] slot, bit mode,
			logic [31:0] delay, logic [7:0] tag);
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {3'b000, tag, delay, mode, slot};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_item(op, slot, mode, delay, tag);
		items_sent++;
	endtask

	// sender pause until every reply is in, then the tick walk tail
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.replies_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic random_item();
		int pick;
		vtt_pkg::op_t op;
		logic [31:0] delay;
		pick = $urandom_range(99);
		if (sb.nlive > 12 && pick < 50) op = vtt_pkg::OP_STOP;
		else if (pick < 25) op = vtt_pkg::OP_START;
		else if (pick < 40) op = vtt_pkg::OP_RESET;
		else if (pick < 55) op = vtt_pkg::OP_STOP;
		else op = vtt_pkg::OP_TICK;
		pick = $urandom_range(99);
		if (pick < 80) delay = $urandom_range(6, 1);
		else if (pick < 88) delay = 32'd0;
		else delay = $urandom;
		send_item(op, 4'($urandom_range(15)), 1'($urandom_range(1)), delay,
			8'($urandom_range(255)));
	endtask

	// run length safety net
	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		sb = new();
		sb.clear();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = vtt_pkg::OP_TICK;
		idle_pct = 0;
		stall_pct = 0;
		long_hold = 1'b0;
		items_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty tick, fill the table, full start, bad handles
		send_item(vtt_pkg::OP_TICK, 4'd0, 1'b0, 32'd0, 8'd0);
		send_item(vtt_pkg::OP_RESET, 4'd15, 1'b1, 32'hFFFF_FFFF, 8'hFF);
		send_item(vtt_pkg::OP_STOP, 4'd9, 1'b0, 32'd0, 8'd0);
		for (int i = 0; i < SLOTS; i++)
			send_item(vtt_pkg::OP_START, 4'(15 - i), i[0],
				(i < 2) ? 32'hFFFF_FFFF : 32'(i + 1), (i == 0) ? 8'hFF : 8'(i));
		send_item(vtt_pkg::OP_START, 4'd0, 1'b1, 32'd3, 8'hAA);
		send_item(vtt_pkg::OP_STOP, 4'd0, 1'b0, 32'd0, 8'd0);
		send_item(vtt_pkg::OP_RESET, 4'd0, 1'b0, 32'd1, 8'd5);
		send_item(vtt_pkg::OP_RESET, 4'd5, 1'b1, 32'd1, 8'h55);
		send_item(vtt_pkg::OP_TICK, 4'd0, 1'b0, 32'd0, 8'd0);
		send_item(vtt_pkg::OP_TICK, 4'd0, 1'b0, 32'd0, 8'd0);
		send_item(vtt_pkg::OP_TICK, 4'd0, 1'b0, 32'd0, 8'd0);
		drain();

		// random phases: no pressure (one long hold-off), sender idles, receiver stalls, then both
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 21 : 57) : 0;
			stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 21 : 57) : 0;
			if (ph == 0) long_hold <= 1'b1;
			for (int n = 0; n < 85; n++) begin
				random_item();
				if (ph == 0 && n == 40) begin
					idle_pct = 0;
					drain();
				end
			end
			drain();
		end

		$display("Ran %0d items: %0d replies checked, %0d timer expiries.",
			items_sent, sb.checked, sb.expiries);
		if (sb.errors == 0 && sb.replies_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/vtt_pkg.sv
hw/rtl/virtual_timer_table.sv
hw/rtl/vtt_check.sv
sim/tb_virtual_timer_table.sv
